FILE: rtl/dnse_pkg.sv
// shared constants and side-data types for the diode newton step evaluator
// no dependencies; imported by the step modules and the top level
package dnse_pkg;

    localparam int QB        = 56;   // fraction bits of the internal log/exp arithmetic
    localparam int LOG_STEPS = 56;
    localparam int EXP_TERMS = 20;
    localparam int NOFS      = 93;   // bias that keeps the reduction quotient positive

    localparam logic [63:0] LN2_Q     = 64'h00B1_7217_F7D1_CF79;
    localparam logic [63:0] ONE_Q     = 64'd1 << QB;
    localparam logic [62:0] MAX63     = '1;
    localparam logic [62:0] G_LIM     = MAX63 / 63'd40;
    localparam logic [63:0] DIV5_M    = 64'hCCCC_CCCC_CCCC_CCCD;
    localparam logic [63:0] RECIP_LN2 = 64'(((128'd1) << 119) / {64'd0, LN2_Q});
    localparam logic [63:0] U_BIAS    = 64'(NOFS) * LN2_Q;

    typedef struct packed {
        logic signed [31:0] vnew;
        logic signed [31:0] vk;
        logic               lim;
        logic               dom;
        logic [5:0]         m;
    } t_log_side;

    typedef struct packed {
        logic signed [31:0] v;
        logic signed [31:0] vk;
        logic               ovf;
        logic               dom;
        logic               esat;
        logic               ezero;
        logic [7:0]         q;
    } t_exp_side;

    typedef struct packed {
        logic signed [31:0] v;
        logic signed [31:0] vk;
        logic [62:0]        cur;
        logic               ovf;
        logic               dom;
    } t_fin_side;

endpackage

FILE: rtl/dnse_mul64.sv
// two-stage pipelined 64x64 unsigned multiplier with side data alongside
// built from four 32x32 partial products; no package dependency
module dnse_mul64 #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [63:0]       i_a,
    input  logic [63:0]       i_b,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [127:0]      o_prod,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_vld1, r_vld2;
    logic [63:0]       r_p00, r_p01, r_p10, r_p11;
    logic [SIDE_W-1:0] r_side1, r_side2;
    logic [127:0]      r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p00   <= 64'(i_a[31:0])  * 64'(i_b[31:0]);
        r_p01   <= 64'(i_a[31:0])  * 64'(i_b[63:32]);
        r_p10   <= 64'(i_a[63:32]) * 64'(i_b[31:0]);
        r_p11   <= 64'(i_a[63:32]) * 64'(i_b[63:32]);
        r_side1 <= i_side;
        r_prod  <= {64'd0, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
                 + {r_p11, 64'd0};
        r_side2 <= r_side1;
    end

    assign o_vld  = r_vld2;
    assign o_prod = r_prod;
    assign o_side = r_side2;

endmodule

FILE: rtl/dnse_log_step.sv
// one bit of the binary logarithm: square the mantissa and renormalise
// depends on dnse_pkg and dnse_mul64
module dnse_log_step import dnse_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [63:0]       i_y,
    input  logic [QB-1:0]     i_f,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [63:0]       o_y,
    output logic [QB-1:0]     o_f,
    output logic [SIDE_W-1:0] o_side
);

    localparam int MW = QB + SIDE_W;

    logic          m_vld;
    logic [127:0]  m_prod;
    logic [MW-1:0] m_side;
    logic [63:0]   sq;
    logic          bit_set;

    logic              r_vld;
    logic [63:0]       r_y;
    logic [QB-1:0]     r_f;
    logic [SIDE_W-1:0] r_side;

    dnse_mul64 #(.SIDE_W(MW)) u_sq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (i_vld),
        .i_a    (i_y),
        .i_b    (i_y),
        .i_side ({i_f, i_side}),
        .o_vld  (m_vld),
        .o_prod (m_prod),
        .o_side (m_side)
    );

    assign sq      = m_prod[QB+63:QB];
    assign bit_set = sq >= (64'd1 << (QB + 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y    <= bit_set ? (sq >> 1) : sq;
        r_f    <= {m_side[MW-2:SIDE_W], bit_set};
        r_side <= m_side[SIDE_W-1:0];
    end

    assign o_vld  = r_vld;
    assign o_y    = r_y;
    assign o_f    = r_f;
    assign o_side = r_side;

endmodule

FILE: rtl/dnse_exp_term.sv
// one taylor term of e^r: term = (term*r >> QB) / K, accumulated into the sum
// depends on dnse_pkg and dnse_mul64; divide by K through a reciprocal and one correction
module dnse_exp_term import dnse_pkg::*; #(
    parameter int K      = 1,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [63:0]       i_term,
    input  logic [63:0]       i_sum,
    input  logic [63:0]       i_r,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [63:0]       o_term,
    output logic [63:0]       o_sum,
    output logic [63:0]       o_r,
    output logic [SIDE_W-1:0] o_side
);

    localparam logic [63:0] KV = 64'(K);
    localparam logic [63:0] MK = 64'hFFFF_FFFF_FFFF_FFFF / KV;
    localparam int AW = 128 + SIDE_W;
    localparam int BW = 64 + AW;

    logic          a_vld, b_vld;
    logic [127:0]  a_prod, b_prod;
    logic [AW-1:0] a_side;
    logic [BW-1:0] b_side;
    logic [63:0]   p, bp, q_est, rem, q;

    logic              r_vld;
    logic [63:0]       r_term, r_sum, r_r;
    logic [SIDE_W-1:0] r_side;

    dnse_mul64 #(.SIDE_W(AW)) u_mul_r (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (i_vld),
        .i_a    (i_term),
        .i_b    (i_r),
        .i_side ({i_sum, i_r, i_side}),
        .o_vld  (a_vld),
        .o_prod (a_prod),
        .o_side (a_side)
    );

    assign p = a_prod[QB+63:QB];

    dnse_mul64 #(.SIDE_W(BW)) u_mul_k (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (a_vld),
        .i_a    (p),
        .i_b    (MK),
        .i_side ({p, a_side}),
        .o_vld  (b_vld),
        .o_prod (b_prod),
        .o_side (b_side)
    );

    // estimate is exact or one short
    assign bp    = b_side[BW-1:AW];
    assign q_est = b_prod[127:64];
    assign rem   = bp - q_est * KV;
    assign q     = q_est + 64'(rem >= KV);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_term <= q;
        r_sum  <= b_side[AW-1:AW-64] + q;
        r_r    <= b_side[SIDE_W+63:SIDE_W];
        r_side <= b_side[SIDE_W-1:0];
    end

    assign o_vld  = r_vld;
    assign o_term = r_term;
    assign o_sum  = r_sum;
    assign o_r    = r_r;
    assign o_side = r_side;

endmodule

FILE: rtl/diode_newton_step_evaluator.sv
// top level of the diode newton step evaluator: limiting, log, exp and companion terms
// depends on dnse_pkg, dnse_mul64, dnse_log_step and dnse_exp_term
//
// usage:
//   an item (solved and previous junction voltage) is taken at a rising edge with
//   start high and busy low; busy is always low, so one item can enter every cycle
//   each result appears on the o_ result ports for exactly one cycle with o_done
//   high, in the order the items went in
//   the chain is made of 56 log steps of three stages each,
//   20 taylor terms of five stages each, plus reduction, limiting and product stages
//   throughput is one item per cycle
//   the limit threshold is written with i_cfg_we/i_cfg_data while no item is in
//   flight; it takes effect on the next item
//   reset clears all valid bits and loads the threshold with 0.1 V; results in
//   flight are dropped
//   the receiver cannot stall, so there is no back-pressure anywhere in the pipe
module diode_newton_step_evaluator import dnse_pkg::*; #(
    parameter int FRAC_BITS = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_solved_voltage,
    input  logic signed [31:0] i_previous_voltage,
    input  logic               i_cfg_we,
    input  logic [30:0]        i_cfg_data,
    output logic               o_done,
    output logic signed [31:0] o_limited_voltage,
    output logic [62:0]        o_diode_current,
    output logic [62:0]        o_conductance,
    output logic signed [63:0] o_equivalent_current,
    output logic               o_stamp_enable,
    output logic [31:0]        o_voltage_change,
    output logic               o_overflow_flag,
    output logic               o_domain_flag
);

    localparam logic [30:0] THR_RESET = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [38:0] ONE_F39   = 39'd1 << FRAC_BITS;
    localparam logic [62:0] ONE_F63   = 63'd1 << FRAC_BITS;
    localparam logic signed [37:0] X_LIM = 38'sd64 <<< FRAC_BITS;
    localparam int LSW = $bits(t_log_side);
    localparam int ESW = $bits(t_exp_side);
    localparam int FSW = $bits(t_fin_side);

    // configuration
    logic [30:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_data;
        end
    end

    assign busy = 1'b0;

    // front: input register, log argument, leading one, normalise
    logic               r0_vld, r1_vld, r2_vld, r3_vld;
    logic signed [31:0] r0_vnew, r0_vk;
    logic [38:0]        r1_a, r2_a;
    t_log_side          r1_side, r2_side, r3_side;
    logic [5:0]         r2_m;
    logic [63:0]        r3_y;

    logic signed [32:0] s1_diff;
    logic signed [39:0] s1_a;
    logic               s1_lim, s1_dom;
    logic [5:0]         s2_m;

    assign s1_diff = 33'(r0_vnew) - 33'(r0_vk);
    assign s1_a    = (40'sd1 <<< FRAC_BITS) + 40'(s1_diff) * 40'sd40;
    assign s1_lim  = r0_vnew > $signed({1'b0, r_thr});
    assign s1_dom  = s1_lim && (s1_a <= 40'sd0);

    always_comb begin
        s2_m = '0;
        for (int i = 0; i < 39; i++) begin
            if (r1_a[i]) s2_m = 6'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r0_vld <= start && !busy;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_vnew      <= i_solved_voltage;
        r0_vk        <= i_previous_voltage;
        r1_a         <= (s1_lim && !s1_dom) ? s1_a[38:0] : ONE_F39;
        r1_side.vnew <= r0_vnew;
        r1_side.vk   <= r0_vk;
        r1_side.lim  <= s1_lim;
        r1_side.dom  <= s1_dom;
        r1_side.m    <= '0;
        r2_a         <= r1_a;
        r2_m         <= s2_m;
        r2_side      <= r1_side;
        r3_y         <= 64'(r2_a) << (6'(QB) - r2_m);
        r3_side      <= {r2_side.vnew, r2_side.vk, r2_side.lim, r2_side.dom, r2_m};
    end

    // log2 fraction bits
    logic          lg_vld  [0:LOG_STEPS];
    logic [63:0]   lg_y    [0:LOG_STEPS];
    logic [QB-1:0] lg_f    [0:LOG_STEPS];
    logic [LSW-1:0] lg_side [0:LOG_STEPS];

    assign lg_vld[0]  = r3_vld;
    assign lg_y[0]    = r3_y;
    assign lg_f[0]    = '0;
    assign lg_side[0] = r3_side;

    for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
        dnse_log_step #(.SIDE_W(LSW)) u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (lg_vld[g]),
            .i_y    (lg_y[g]),
            .i_f    (lg_f[g]),
            .i_side (lg_side[g]),
            .o_vld  (lg_vld[g+1]),
            .o_y    (lg_y[g+1]),
            .o_f    (lg_f[g+1]),
            .o_side (lg_side[g+1])
        );
    end

    // ln(a)/40 and limited voltage
    t_log_side         l1_in;
    logic signed [6:0] l1_ip;
    logic              l1_neg;
    logic              r_l1_vld, r_l1_neg;
    logic [63:0]       r_l1_mag;
    t_log_side         r_l1_side;

    assign l1_in  = lg_side[LOG_STEPS];
    assign l1_ip  = $signed({1'b0, l1_in.m}) - 7'(FRAC_BITS);
    assign l1_neg = l1_ip < 7'sd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1_vld <= 1'b0;
        end else begin
            r_l1_vld <= lg_vld[LOG_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_l1_neg  <= l1_neg;
        r_l1_side <= l1_in;
        r_l1_mag  <= l1_neg ? ((64'(-l1_ip) << QB) - 64'(lg_f[LOG_STEPS]))
                            : ((64'(l1_ip) << QB) + 64'(lg_f[LOG_STEPS]));
    end

    logic           l2_vld, l3_vld;
    logic [127:0]   l2_prod, l3_prod;
    logic [LSW:0]   l2_side, l3_side;
    logic [63:0]    l2_x5;

    dnse_mul64 #(.SIDE_W(LSW + 1)) u_mul_ln2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_l1_vld),
        .i_a    (r_l1_mag),
        .i_b    (LN2_Q),
        .i_side ({r_l1_neg, r_l1_side}),
        .o_vld  (l2_vld),
        .o_prod (l2_prod),
        .o_side (l2_side)
    );

    // divide by 40 << (QB-FRAC_BITS): a shift, then divide by five
    assign l2_x5 = 64'(l2_prod >> (QB + 59 - FRAC_BITS));

    dnse_mul64 #(.SIDE_W(LSW + 1)) u_mul_div5 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (l2_vld),
        .i_a    (l2_x5),
        .i_b    (DIV5_M),
        .i_side (l2_side),
        .o_vld  (l3_vld),
        .o_prod (l3_prod),
        .o_side (l3_side)
    );

    t_log_side          l4_in;
    logic [39:0]        l4_d;
    logic signed [41:0] l4_sum;
    logic signed [31:0] l4_sat, l4_v;
    logic               l4_sovf;
    logic               r_l4_vld;
    t_exp_side          r_l4_side;

    assign l4_in  = l3_side[LSW-1:0];
    assign l4_d   = l3_prod[105:66];
    assign l4_sum = 42'(l4_in.vk) + (l3_side[LSW] ? -$signed({2'b0, l4_d})
                                                  : $signed({2'b0, l4_d}));

    always_comb begin
        l4_sovf = 1'b0;
        l4_sat  = 32'(l4_sum);
        if (l4_sum > 42'sd2147483647) begin
            l4_sat  = 32'sh7FFF_FFFF;
            l4_sovf = 1'b1;
        end else if (l4_sum < -42'sd2147483648) begin
            l4_sat  = 32'sh8000_0000;
            l4_sovf = 1'b1;
        end
        if (l4_in.dom) l4_v = 32'sh8000_0000;
        else if (l4_in.lim) l4_v = l4_sat;
        else l4_v = l4_in.vnew;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l4_vld <= 1'b0;
        end else begin
            r_l4_vld <= l3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_l4_side.v     <= l4_v;
        r_l4_side.vk    <= l4_in.vk;
        r_l4_side.ovf   <= l4_in.lim && !l4_in.dom && l4_sovf;
        r_l4_side.dom   <= l4_in.dom;
        r_l4_side.esat  <= 1'b0;
        r_l4_side.ezero <= 1'b0;
        r_l4_side.q     <= '0;
    end

    // range reduction x = n*ln2 + r
    logic signed [37:0] e1_x;
    logic signed [63:0] e1_xq;
    logic               e1_sat, e1_zero;
    logic               r_e1_vld;
    logic [63:0]        r_e1_u;
    t_exp_side          r_e1_side;

    assign e1_x    = 38'(r_l4_side.v) * 38'sd40;
    assign e1_sat  = e1_x >= X_LIM;
    assign e1_zero = e1_x <= -X_LIM;
    assign e1_xq   = 64'(e1_x) <<< (QB - FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_vld <= 1'b0;
        end else begin
            r_e1_vld <= r_l4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e1_u    <= (e1_sat || e1_zero) ? 64'd0 : (64'(e1_xq) + U_BIAS);
        r_e1_side <= {r_l4_side.v, r_l4_side.vk, r_l4_side.ovf, r_l4_side.dom,
                      e1_sat, e1_zero, r_l4_side.q};
    end

    logic              e2_vld;
    logic [127:0]      e2_prod;
    logic [ESW+63:0]   e2_side;
    t_exp_side         e3_in;
    logic [7:0]        e3_qe;
    logic [63:0]       e3_u, e3_rem;
    logic              e3_up;
    logic              r_e3_vld;
    logic [63:0]       r_e3_r;
    t_exp_side         r_e3_side;

    dnse_mul64 #(.SIDE_W(ESW + 64)) u_mul_rln2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_e1_vld),
        .i_a    (r_e1_u),
        .i_b    (RECIP_LN2),
        .i_side ({r_e1_u, r_e1_side}),
        .o_vld  (e2_vld),
        .o_prod (e2_prod),
        .o_side (e2_side)
    );

    assign e3_in  = e2_side[ESW-1:0];
    assign e3_qe  = e2_prod[126:119];
    assign e3_u   = e2_side[ESW+63:ESW];
    assign e3_rem = e3_u - 64'(e3_qe) * LN2_Q;
    assign e3_up  = e3_rem >= LN2_Q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e3_vld <= 1'b0;
        end else begin
            r_e3_vld <= e2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e3_r    <= e3_up ? (e3_rem - LN2_Q) : e3_rem;
        r_e3_side <= {e3_in.v, e3_in.vk, e3_in.ovf, e3_in.dom, e3_in.esat, e3_in.ezero,
                      8'(e3_qe + 8'(e3_up))};
    end

    // taylor sum of e^r
    logic           tx_vld  [0:EXP_TERMS];
    logic [63:0]    tx_term [0:EXP_TERMS];
    logic [63:0]    tx_sum  [0:EXP_TERMS];
    logic [63:0]    tx_r    [0:EXP_TERMS];
    logic [ESW-1:0] tx_side [0:EXP_TERMS];

    assign tx_vld[0]  = r_e3_vld;
    assign tx_term[0] = ONE_Q;
    assign tx_sum[0]  = ONE_Q;
    assign tx_r[0]    = r_e3_r;
    assign tx_side[0] = r_e3_side;

    for (genvar g = 0; g < EXP_TERMS; g++) begin : g_exp
        dnse_exp_term #(.K(g + 1), .SIDE_W(ESW)) u_term (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (tx_vld[g]),
            .i_term (tx_term[g]),
            .i_sum  (tx_sum[g]),
            .i_r    (tx_r[g]),
            .i_side (tx_side[g]),
            .o_vld  (tx_vld[g+1]),
            .o_term (tx_term[g+1]),
            .o_sum  (tx_sum[g+1]),
            .o_r    (tx_r[g+1]),
            .o_side (tx_side[g+1])
        );
    end

    // scale by 2^n into Q.F
    t_exp_side         p1_in;
    logic signed [9:0] p1_sh, p1_rs;
    logic [63:0]       p1_sum;
    logic [62:0]       p1_e;
    logic              p1_eovf;
    logic              r_p1_vld, r_p1_eovf;
    logic [62:0]       r_p1_e;
    t_exp_side         r_p1_side;

    assign p1_in  = tx_side[EXP_TERMS];
    assign p1_sum = tx_sum[EXP_TERMS];
    assign p1_sh  = $signed({2'b0, p1_in.q}) - 10'(NOFS) + 10'(FRAC_BITS) - 10'(QB);
    assign p1_rs  = -p1_sh;

    always_comb begin
        p1_eovf = 1'b0;
        p1_e    = '0;
        if (p1_in.esat) begin
            p1_eovf = 1'b1;
            p1_e    = MAX63;
        end else if (p1_in.ezero) begin
            p1_e = '0;
        end else if (p1_sh < 10'sd0) begin
            p1_e = (p1_rs >= 10'sd64) ? 63'd0 : 63'(p1_sum >> p1_rs[5:0]);
        end else if (p1_sh >= 10'sd63 || p1_sum > ({1'b0, MAX63} >> p1_sh[5:0])) begin
            p1_eovf = 1'b1;
            p1_e    = MAX63;
        end else begin
            p1_e = 63'(p1_sum << p1_sh[5:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else begin
            r_p1_vld <= tx_vld[EXP_TERMS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_e    <= p1_e;
        r_p1_eovf <= p1_eovf;
        r_p1_side <= p1_in;
    end

    // current and conductance
    logic [62:0] p2_cur, p2_g;
    logic        p2_ovf;
    logic        r_p2_vld;
    logic [62:0] r_p2_g;
    t_fin_side   r_p2_side;

    always_comb begin
        p2_ovf = r_p1_side.ovf;
        if (r_p1_side.v <= 32'sd0) begin
            p2_cur = '0;
        end else if (r_p1_eovf) begin
            p2_cur = MAX63;
            p2_ovf = 1'b1;
        end else begin
            p2_cur = (r_p1_e >= ONE_F63) ? (r_p1_e - ONE_F63) : 63'd0;
        end
        if (r_p1_eovf || r_p1_e > G_LIM) begin
            p2_g   = MAX63;
            p2_ovf = 1'b1;
        end else begin
            p2_g = r_p1_e * 63'd40;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else begin
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2_g        <= p2_g;
        r_p2_side.v   <= r_p1_side.v;
        r_p2_side.vk  <= r_p1_side.vk;
        r_p2_side.cur <= p2_cur;
        r_p2_side.ovf <= p2_ovf;
        r_p2_side.dom <= r_p1_side.dom;
    end

    // g*|v| and the companion source
    logic [31:0]   p3_absv;
    logic          p3_vld;
    logic [127:0]  p3_prod;
    logic [FSW-1:0] p3_side_raw;
    t_fin_side     p4_in;
    logic [63:0]   p4_mag, p4_cur;
    logic          p4_big;
    logic signed [32:0] p4_diff;
    logic [63:0]   p4_j;
    logic          p4_ovf;

    assign p3_absv = r_p2_side.v[31] ? 32'(-33'(r_p2_side.v)) : 32'(r_p2_side.v);

    dnse_mul64 #(.SIDE_W(FSW)) u_mul_gv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vld  (r_p2_vld),
        .i_a    ({1'b0, r_p2_g}),
        .i_b    (64'(p3_absv)),
        .i_side (r_p2_side),
        .o_vld  (p3_vld),
        .o_prod (p3_prod),
        .o_side (p3_side_raw)
    );

    assign p4_in   = p3_side_raw;
    assign p4_mag  = p3_prod[FRAC_BITS+63:FRAC_BITS];
    assign p4_big  = |p3_prod[127:64+FRAC_BITS];
    assign p4_cur  = {1'b0, p4_in.cur};
    assign p4_diff = 33'(p4_in.v) - 33'(p4_in.vk);

    always_comb begin
        p4_ovf = p4_in.ovf;
        if (!p4_in.v[31]) begin
            if (p4_big || p4_mag > (p4_cur + 64'h8000_0000_0000_0000)) begin
                p4_j   = 64'h8000_0000_0000_0000;
                p4_ovf = 1'b1;
            end else begin
                p4_j = p4_cur - p4_mag;
            end
        end else begin
            if (p4_big || p4_mag > ({1'b0, MAX63} - p4_cur)) begin
                p4_j   = {1'b0, MAX63};
                p4_ovf = 1'b1;
            end else begin
                p4_j = p4_cur + p4_mag;
            end
        end
    end

    // conductance has to line up with the two product stages
    logic [62:0] r_g_d1, r_g_d2;

    always_ff @(posedge i_clk) begin
        r_g_d1 <= r_p2_g;
        r_g_d2 <= r_g_d1;
    end

    logic r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= p3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_limited_voltage    <= p4_in.v;
        o_diode_current      <= p4_in.cur;
        o_conductance        <= r_g_d2;
        o_equivalent_current <= $signed(p4_j);
        o_stamp_enable       <= !p4_in.v[31];
        o_voltage_change     <= p4_diff[32] ? 32'(-p4_diff) : 32'(p4_diff);
        o_overflow_flag      <= p4_ovf;
        o_domain_flag        <= p4_in.dom;
    end

    assign o_done = r_done;

    a_domain_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_domain_flag |-> o_limited_voltage == 32'sh8000_0000)
        else $error("domain result without clamped voltage");

    a_stamp_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_stamp_enable == !o_limited_voltage[31])
        else $error("stamp enable disagrees with voltage sign");

    a_neg_no_current: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_stamp_enable |-> o_diode_current == 63'd0)
        else $error("current on a reverse-biased result");

endmodule
